@@ design/dslact_pkg.sv @@
// Package for the DSL line activation state machine.
// Holds phase codes, state numbers, table row type and the per-mode tables.
package dslact_pkg;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_RUN  = 2'd2;

    localparam logic [4:0] ST_TEST = 5'd18;
    localparam logic [4:0] LT_TRANSPARENT = 5'd12;
    localparam logic [4:0] NT_TRANSPARENT = 5'd11;

    localparam logic [7:0] NOTIM = 8'hFF;

    localparam logic [3:0] CMD_RESET   = 4'h1;
    localparam logic [3:0] CMD_LT_UNRST = 4'h0;
    localparam logic [3:0] CMD_NT_UNRST = 4'hf;

    localparam logic [1:0] CFG_TERM_MODE = 2'd0;
    localparam logic [1:0] CFG_CHANNELS  = 2'd1;
    localparam logic [1:0] CFG_GUARD     = 2'd2;

    localparam int TIMER_W = 32;

    typedef struct packed {
        logic [4:0] st;
        logic [7:0] arm1;
        logic [7:0] arm2;
        logic       has_cmd;
        logic [3:0] cmd;
        logic [7:0] tend;
        logic [4:0] next;
    } t_row;

    typedef struct packed {
        logic       cmd_valid;
        logic [3:0] cmd_code;
        logic [7:0] cmd_channels;
        logic [4:0] line_state;
        logic       reached_transparent;
        logic       guard_expired;
        logic       last;
    } t_result;

    function automatic t_row mk(input int s, input int a1, input int a2, input int h,
                                input int c, input int e, input int n);
        t_row r;
        r.st = 5'(s); r.arm1 = 8'(a1); r.arm2 = 8'(a2); r.has_cmd = 1'(h);
        r.cmd = 4'(c); r.tend = 8'(e); r.next = 5'(n);
        return r;
    endfunction

    function automatic t_row lt_row(input logic [4:0] i);
        t_row r;
        case (i)
            5'd0:  r = mk(0, 255, 255, 0, 0, 255, 1);
            5'd1:  r = mk(1, 9, 255, 0, 0, 9, 7);
            5'd2:  r = mk(18, 255, 255, 1, 0, 255, 2);
            5'd3:  r = mk(2, 255, 255, 0, 0, 255, 4);
            5'd4:  r = mk(3, 2, 255, 0, 0, 2, 4);
            5'd5:  r = mk(4, 1, 2, 1, 8, 2, 5);
            5'd6:  r = mk(5, 255, 255, 0, 0, 255, 6);
            5'd7:  r = mk(6, 1, 255, 1, 8, 255, 7);
            5'd8:  r = mk(7, 5, 255, 0, 0, 5, 8);
            5'd9:  r = mk(8, 6, 255, 1, 10, 6, 9);
            5'd10: r = mk(9, 255, 255, 0, 0, 255, 10);
            5'd11: r = mk(10, 255, 255, 1, 13, 255, 11);
            5'd12: r = mk(11, 8, 255, 0, 0, 8, 12);
            5'd13: r = mk(13, 255, 255, 1, 13, 255, 10);
            5'd14: r = mk(16, 255, 255, 1, 4, 255, 0);
            5'd15: r = mk(15, 255, 255, 1, 4, 255, 17);
            5'd16: r = mk(17, 255, 255, 0, 0, 255, 0);
            5'd17: r = mk(14, 10, 255, 0, 0, 10, 19);
            5'd18: r = mk(19, 255, 255, 0, 0, 255, 2);
            default: r = mk(31, 255, 255, 0, 0, 255, 0);
        endcase
        return r;
    endfunction

    function automatic t_row nt_row(input logic [4:0] i);
        t_row r;
        case (i)
            5'd0:  r = mk(0, 7, 255, 1, 15, 7, 1);
            5'd1:  r = mk(18, 255, 255, 1, 15, 255, 1);
            5'd2:  r = mk(1, 14, 255, 0, 0, 14, 2);
            5'd3:  r = mk(2, 255, 255, 1, 0, 255, 3);
            5'd4:  r = mk(3, 255, 255, 0, 0, 255, 4);
            5'd5:  r = mk(4, 1, 11, 1, 8, 11, 5);
            5'd6:  r = mk(5, 12, 255, 0, 0, 12, 8);
            5'd7:  r = mk(6, 255, 255, 0, 0, 255, 7);
            5'd8:  r = mk(6, 255, 255, 0, 0, 1, 16);
            5'd9:  r = mk(7, 255, 255, 0, 0, 255, 16);
            5'd10: r = mk(8, 255, 255, 0, 0, 255, 9);
            5'd11: r = mk(9, 255, 255, 1, 12, 255, 10);
            5'd12: r = mk(10, 255, 255, 0, 0, 255, 11);
            5'd13: r = mk(11, 255, 255, 0, 0, 255, 15);
            5'd14: r = mk(15, 255, 255, 0, 0, 255, 16);
            5'd15: r = mk(16, 13, 255, 0, 0, 13, 0);
            default: r = mk(31, 255, 255, 0, 0, 255, 0);
        endcase
        return r;
    endfunction

    function automatic logic [15:0] limit_ms(input logic [3:0] t);
        logic [15:0] v;
        case (t)
            4'd1: v = 16'd15000; 4'd2: v = 16'd3;    4'd3: v = 16'd40;
            4'd4: v = 16'd6000;  4'd5: v = 16'd1000; 4'd6: v = 16'd6000;
            4'd7: v = 16'd40;    4'd8: v = 16'd24;   4'd9: v = 16'd40;
            4'd10: v = 16'd40;   4'd11: v = 16'd9;   4'd12: v = 16'd5500;
            4'd13: v = 16'd15000;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

@@ design/dsl_line_activation_fsm_unit.sv @@
// Top level of the DSL line activation state machine.
// Uses dslact_pkg and dslact_core; checked by dslact_checker.
//
// Input channel s_axis: one item per start request or poll tick.
//   tdata holds req_type, ind_valid, ind_code from the lowest bit up.
// Output channel m_axis: one or two result items per input item; tlast marks
//   the final one. tdata holds cmd_valid, cmd_code, cmd_channels, line_state,
//   reached_transparent, guard_expired from the lowest bit up.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data; the user
// must write it only while idle, which the block itself does not enforce. An
// accepted item is held in the input register and evaluated there; its first result
// goes to the output register once that is free, and a second result follows when
// it is free again. Throughput is one item per cycle for single-result items while
// m_axis does not stall; a two-result item holds off the next until its second
// result is loaded. A stall on m_axis holds the results and drops s_axis_tready
// once the internal stage is full. Reset clears the state machine to the test
// state, idle, with all timers and the tick counter at zero.
module dsl_line_activation_fsm_unit #(
    parameter int NUM_TIMERS = 15,
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // req_type, ind_valid, ind_code[3:0], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // cmd_valid, cmd_code, cmd_channels, line_state,
                                       // reached_transparent, guard_expired, zero pad
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import dslact_pkg::*;

    logic        r_term_mode;
    logic [7:0]  r_channels;
    logic [7:0]  r_guard;
    logic [4:0]  r_state;
    logic [1:0]  r_phase;
    logic [31:0] r_tick;
    logic [31:0] r_deadline;
    logic [NUM_TIMERS-1:0][31:0] r_stamps;

    logic        r_in_valid;
    logic [5:0]  r_in;

    logic        r_pend;
    t_result     r_res2;
    logic        r_ovalid;
    t_result     r_ores;

    logic [4:0]  n_state;
    logic [1:0]  n_phase;
    logic [31:0] n_tick;
    logic [31:0] n_deadline;
    logic [NUM_TIMERS-1:0][31:0] n_stamps;
    logic [3:0]  c_buf [0:1];
    logic [1:0]  c_n;
    logic        c_done;
    logic        c_gexp;
    logic [31:0] c_gticks;
    logic [31:0] c_diff;
    logic        c_due;
    logic [4:0]  c_next;
    logic        c_evt_cmd;
    logic [3:0]  c_evt_code;
    logic [4:0]  c_enter;
    logic        c_do_enter;
    t_row        c_row;
    t_result     c_r1;
    t_result     c_r2;
    logic        c_two;
    logic        c_emit;
    logic        c_out_free;

    dslact_core #(.NUM_TIMERS(NUM_TIMERS), .TICKS_PER_SECOND(TICKS_PER_SECOND)) u_core (
        .i_term_mode(r_term_mode),
        .i_state    (r_state),
        .i_ind_valid(r_in[1]),
        .i_ind_code (r_in[5:2]),
        .i_tick     (r_tick + 32'd1),
        .i_stamps   (r_stamps),
        .o_next     (c_next),
        .o_evt_cmd  (c_evt_cmd),
        .o_evt_code (c_evt_code)
    );

    function automatic t_row find_row(input logic m, input logic [4:0] s);
        t_row r;
        t_row c;
        logic f;
        r = m ? nt_row(5'd0) : lt_row(5'd0);
        f = 1'b0;
        for (int i = 0; i < 19; i++) begin
            c = m ? nt_row(5'(i)) : lt_row(5'(i));
            if (!f && (!m || i < 16) && c.st == s) begin
                r = c;
                f = 1'b1;
            end
        end
        return r;
    endfunction

    assign c_out_free = !r_ovalid || m_axis_tready;
    // The evaluation stage fires when the output register can take its first result.
    assign c_emit = r_in_valid && !r_pend && c_out_free;
    assign s_axis_tready = !r_in_valid || c_emit;

    always_comb begin
        c_gticks = 32'(r_guard * TICKS_PER_SECOND);
        c_diff = r_tick + 32'd1 - r_deadline;
        c_due = !c_diff[31];
        n_state = r_state;
        n_phase = r_phase;
        n_tick = r_tick;
        n_deadline = r_deadline;
        n_stamps = r_stamps;
        c_buf[0] = '0;
        c_buf[1] = '0;
        c_n = '0;
        c_done = 1'b0;
        c_gexp = 1'b0;
        c_do_enter = 1'b0;
        c_enter = r_state;
        if (!r_in[0]) begin
            c_buf[0] = CMD_RESET;
            c_buf[1] = r_term_mode ? CMD_NT_UNRST : CMD_LT_UNRST;
            c_n = 2'd2;
            n_state = ST_TEST;
            n_phase = PH_WAIT;
            n_deadline = r_tick + c_gticks;
        end else begin
            n_tick = r_tick + 32'd1;
            if (r_phase == PH_WAIT) begin
                if (r_in[1] || c_due) begin
                    n_deadline = n_tick + c_gticks;
                    n_phase = PH_RUN;
                    c_do_enter = 1'b1;
                end
            end else if (r_phase == PH_RUN) begin
                if (c_evt_cmd) begin
                    c_buf[0] = c_evt_code;
                    c_n = 2'd1;
                end
                if (r_guard != 8'd0 && c_due) begin
                    c_gexp = 1'b1;
                    n_phase = PH_IDLE;
                end else if (c_next != r_state) begin
                    n_state = c_next;
                    n_deadline = n_tick + c_gticks;
                    if (c_next == (r_term_mode ? NT_TRANSPARENT : LT_TRANSPARENT)) begin
                        c_done = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        c_do_enter = 1'b1;
                        c_enter = c_next;
                    end
                end
            end
        end
        c_row = find_row(r_term_mode, c_enter);
        if (c_do_enter) begin
            if (c_row.arm1 < 8'(NUM_TIMERS))
                n_stamps[c_row.arm1[$clog2(NUM_TIMERS)-1:0]] = n_tick;
            if (c_row.arm2 < 8'(NUM_TIMERS))
                n_stamps[c_row.arm2[$clog2(NUM_TIMERS)-1:0]] = n_tick;
            if (c_row.has_cmd && c_n < 2'd2) begin
                c_buf[c_n[0]] = c_row.cmd;
                c_n = c_n + 2'd1;
            end
        end
        c_two = (c_n == 2'd2);
        c_r1.cmd_valid = (c_n != 2'd0);
        c_r1.cmd_code = c_buf[0];
        c_r1.cmd_channels = (c_n != 2'd0) ? r_channels : 8'd0;
        c_r1.line_state = n_state;
        c_r1.reached_transparent = c_done;
        c_r1.guard_expired = c_gexp;
        c_r1.last = !c_two;
        c_r2 = c_r1;
        c_r2.cmd_valid = 1'b1;
        c_r2.cmd_code = c_buf[1];
        c_r2.cmd_channels = r_channels;
        c_r2.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_mode <= 1'b0;
            r_channels <= '0;
            r_guard <= '0;
            r_state <= ST_TEST;
            r_phase <= PH_IDLE;
            r_tick <= '0;
            r_deadline <= '0;
            r_stamps <= '0;
            r_in_valid <= 1'b0;
            r_pend <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TERM_MODE: r_term_mode <= i_cfg_data[0];
                    CFG_CHANNELS:  r_channels <= i_cfg_data;
                    CFG_GUARD:     r_guard <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
                if (s_axis_tvalid) r_in <= s_axis_tdata[5:0];
            end
            if (c_emit) begin
                r_state <= n_state;
                r_phase <= n_phase;
                r_tick <= n_tick;
                r_deadline <= n_deadline;
                r_stamps <= n_stamps;
                r_ores <= c_r1;
                r_ovalid <= 1'b1;
                r_pend <= c_two;
                r_res2 <= c_r2;
            end else if (r_pend && c_out_free) begin
                r_ores <= r_res2;
                r_ovalid <= 1'b1;
                r_pend <= 1'b0;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast = r_ores.last;
    assign m_axis_tdata = {4'd0, r_ores.guard_expired, r_ores.reached_transparent,
                           r_ores.line_state, r_ores.cmd_channels, r_ores.cmd_code,
                           r_ores.cmd_valid};

endmodule

@@ design/dslact_core.sv @@
// Next-state logic of the activation state machine for one item.
// Depends on dslact_pkg for tables and codes; purely combinational.
module dslact_core #(
    parameter int NUM_TIMERS = 15,
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic                 i_term_mode,
    input  logic [4:0]           i_state,
    input  logic                 i_ind_valid,
    input  logic [3:0]           i_ind_code,
    input  logic [31:0]          i_tick,
    input  logic [NUM_TIMERS-1:0][31:0] i_stamps,
    output logic [4:0]           o_next,
    output logic                 o_evt_cmd,
    output logic [3:0]           o_evt_code
);
    import dslact_pkg::*;

    logic [4:0] v_idx;
    logic [4:0] v_n;
    t_row       v_base;
    t_row       v_scan;
    t_row       v_rows [0:2];
    logic [4:0] v_walk;
    logic       v_evt_hit;
    logic [4:0] v_evt_next;
    logic       v_found;
    logic [3:0] v_ind;
    logic       v_tv;

    function automatic t_row get_row(input logic m, input logic [4:0] i);
        return m ? nt_row(i) : lt_row(i);
    endfunction

    function automatic logic [31:0] tlimit(input logic [7:0] t);
        logic [31:0] v;
        v = '0;
        for (int j = 1; j < 15; j++) begin
            if (t == 8'(j)) begin
                v = 32'((32'(limit_ms(4'(j))) * 32'(TICKS_PER_SECOND)) / 32'd1000);
                if (v == '0) v = 32'd1;
            end
        end
        return v;
    endfunction

    function automatic logic expired(input t_row r, input logic [31:0] tk,
                                     input logic [NUM_TIMERS-1:0][31:0] sp);
        logic x;
        if (r.tend >= 8'(NUM_TIMERS)) begin
            x = 1'b1;
        end else begin
            x = (tk - sp[r.tend[$clog2(NUM_TIMERS)-1:0]]) >= tlimit(r.tend);
        end
        return x;
    endfunction

    always_comb begin
        v_n = i_term_mode ? 5'd16 : 5'd19;
        v_idx = '0;
        v_found = 1'b0;
        v_scan = get_row(i_term_mode, 5'd0);
        for (int i = 0; i < 19; i++) begin
            v_scan = get_row(i_term_mode, 5'(i));
            if (!v_found && 5'(i) < v_n && v_scan.st == i_state) begin
                v_idx = 5'(i);
                v_found = 1'b1;
            end
        end
        v_base = get_row(i_term_mode, v_idx);
        for (int k = 0; k < 3; k++) begin
            v_rows[k] = get_row(i_term_mode, v_idx + 5'(k));
        end
        v_walk = v_base.st;
        for (int k = 2; k >= 0; k--) begin
            if (v_idx + 5'(k) < v_n && v_rows[k].st == v_base.st) begin
                if (expired(v_rows[k], i_tick, i_stamps)) v_walk = v_rows[k].next;
            end
        end
        // A row earlier in the walk wins, but only if all rows before it matched the state.
        if (!(v_idx + 5'd1 < v_n && v_rows[1].st == v_base.st)) begin
            v_walk = expired(v_rows[0], i_tick, i_stamps) ? v_rows[0].next : v_base.st;
        end else if (!(v_idx + 5'd2 < v_n && v_rows[2].st == v_base.st)) begin
            if (expired(v_rows[0], i_tick, i_stamps)) v_walk = v_rows[0].next;
            else if (expired(v_rows[1], i_tick, i_stamps)) v_walk = v_rows[1].next;
            else v_walk = v_base.st;
        end

        v_ind = i_ind_code;
        v_tv = i_ind_valid;
        v_evt_hit = 1'b0;
        v_evt_next = '0;
        o_evt_cmd = 1'b0;
        o_evt_code = '0;
        if (!i_term_mode) begin
            case (i_state)
                5'd6: begin
                    v_evt_hit = 1'b1;
                    if (v_tv && v_ind == 4'd7) v_evt_next = 5'd11;
                    else if (v_tv && v_ind == 4'd9) v_evt_next = 5'd9;
                    else if (v_tv && (v_ind == 4'd15 || v_ind == 4'd11)) begin
                        o_evt_cmd = 1'b1; o_evt_code = 4'h1; v_evt_next = 5'd18;
                    end else begin
                        o_evt_cmd = 1'b1; o_evt_code = 4'h8; v_evt_next = 5'd6;
                    end
                end
                5'd2: begin
                    v_evt_hit = 1'b1;
                    if (v_tv && v_ind == 4'd9) v_evt_next = 5'd9;
                    else if (v_tv && v_ind == 4'd11) begin
                        o_evt_cmd = 1'b1; o_evt_code = 4'h1; v_evt_next = 5'd18;
                    end else begin
                        o_evt_cmd = 1'b1; o_evt_code = 4'h8; v_evt_next = 5'd6;
                    end
                end
                5'd7, 5'd8: begin
                    if (v_tv && v_ind == 4'd7) begin v_evt_hit = 1'b1; v_evt_next = 5'd11; end
                    else if (v_tv && v_ind == 4'd12) begin
                        v_evt_hit = 1'b1; v_evt_next = 5'd12;
                    end
                end
                5'd9: begin
                    v_evt_hit = 1'b1;
                    v_evt_next = 5'd9;
                    if (v_tv && v_ind == 4'd7) v_evt_next = 5'd11;
                    else if (v_tv && v_ind == 4'd12) v_evt_next = 5'd12;
                    else if (v_tv && v_ind == 4'd11) begin
                        o_evt_cmd = 1'b1; o_evt_code = 4'h1; v_evt_next = 5'd18;
                    end else if (v_tv && v_ind == 4'd15) begin
                        o_evt_cmd = 1'b1; o_evt_code = 4'h8; v_evt_next = 5'd6;
                    end
                end
                5'd11: begin
                    v_evt_hit = 1'b1;
                    v_evt_next = 5'd11;
                    if (v_tv && v_ind == 4'd4) begin
                        o_evt_cmd = 1'b1; o_evt_code = 4'h4; v_evt_next = 5'd5;
                    end else if (v_tv && v_ind == 4'd12) v_evt_next = 5'd12;
                    else if (v_tv && v_ind == 4'd13) begin
                        o_evt_cmd = 1'b1; o_evt_code = 4'h4; v_evt_next = 5'd0;
                    end
                end
                5'd0: begin
                    if (v_tv && v_ind == 4'd8) begin v_evt_hit = 1'b1; v_evt_next = 5'd6; end
                    else if (v_tv && v_ind == 4'd15) begin
                        v_evt_hit = 1'b1; o_evt_cmd = 1'b1; o_evt_code = 4'h8;
                        v_evt_next = 5'd2;
                    end
                end
                5'd17: begin
                    if (v_tv && v_ind == 4'd13) begin v_evt_hit = 1'b1; v_evt_next = 5'd0; end
                end
                5'd18: begin
                    if (v_tv && v_ind == 4'd1) begin
                        v_evt_hit = 1'b1; o_evt_cmd = 1'b1; o_evt_code = 4'h0;
                        v_evt_next = 5'd2;
                    end else if (v_tv && v_ind == 4'd15) begin
                        v_evt_hit = 1'b1; o_evt_cmd = 1'b1; o_evt_code = 4'hf;
                        v_evt_next = 5'd2;
                    end
                end
                5'd5: begin
                    if (v_tv && v_ind == 4'd8) begin
                        v_evt_hit = 1'b1; o_evt_cmd = 1'b1; o_evt_code = 4'h8;
                        v_evt_next = 5'd6;
                    end else if (v_tv && (v_ind == 4'd11 || v_ind == 4'd15)) begin
                        v_evt_hit = 1'b1; o_evt_cmd = 1'b1; o_evt_code = 4'h1;
                        v_evt_next = 5'd18;
                    end
                end
                default: begin
                    v_evt_hit = 1'b0;
                end
            endcase
        end else begin
            case (i_state)
                5'd2: begin
                    v_evt_hit = 1'b1;
                    v_evt_next = 5'd2;
                    if (v_tv && v_ind == 4'd8) begin
                        o_evt_cmd = 1'b1; o_evt_code = 4'hc; v_evt_next = 5'd9;
                    end else if (v_tv && v_ind == 4'd7) begin
                        o_evt_cmd = 1'b1; o_evt_code = 4'h0; v_evt_next = 5'd3;
                    end
                end
                5'd3: begin
                    v_evt_hit = 1'b1;
                    o_evt_cmd = 1'b1; o_evt_code = 4'h8;
                    v_evt_next = (v_tv && v_ind == 4'd15) ? 5'd4 : 5'd3;
                end
                5'd4: begin
                    v_evt_hit = 1'b1;
                    v_evt_next = 5'd4;
                    if (v_tv && v_ind == 4'd8) begin
                        o_evt_cmd = 1'b1; o_evt_code = 4'hc; v_evt_next = 5'd9;
                    end
                end
                5'd5: begin
                    if (v_tv && v_ind == 4'd8) begin
                        v_evt_hit = 1'b1; o_evt_cmd = 1'b1; o_evt_code = 4'hc;
                        v_evt_next = 5'd10;
                    end
                end
                5'd9: begin
                    v_evt_hit = 1'b1;
                    v_evt_next = 5'd9;
                    if (v_tv && v_ind == 4'd8) begin
                        o_evt_cmd = 1'b1; o_evt_code = 4'hc; v_evt_next = 5'd10;
                    end else if (v_tv && v_ind == 4'd12) v_evt_next = 5'd11;
                    else if (v_tv && v_ind == 4'd0) begin
                        o_evt_cmd = 1'b1; o_evt_code = 4'hf; v_evt_next = 5'd14;
                    end
                end
                5'd10: begin
                    v_evt_hit = 1'b1;
                    v_evt_next = 5'd10;
                    if (v_tv && v_ind == 4'd12) v_evt_next = 5'd11;
                    else if (v_tv && v_ind == 4'd0) begin
                        o_evt_cmd = 1'b1; o_evt_code = 4'hf; v_evt_next = 5'd14;
                    end else if (v_tv && v_ind == 4'd8) begin
                        o_evt_cmd = 1'b1; o_evt_code = 4'hc;
                    end
                end
                default: begin
                    v_evt_hit = 1'b0;
                end
            endcase
            if (!v_evt_hit && v_tv && v_ind == 4'd8) begin
                v_evt_hit = 1'b1; o_evt_cmd = 1'b1; o_evt_code = 4'hc; v_evt_next = 5'd9;
            end
        end

        o_next = v_evt_hit ? v_evt_next : v_walk;
    end

endmodule

@@ design/dslact_checker.sv @@
// Port-level checker for the DSL line activation state machine.
// Bound to dsl_line_activation_fsm_unit; uses no package.
module dslact_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("data moved");
    a_nocmd_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tlast) else $error("empty not last");
    a_nocmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[12:1] == 12'd0)
        else $error("empty has code");
    a_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[17:13] <= 5'd21) else $error("bad state");
endmodule

bind dsl_line_activation_fsm_unit dslact_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

@@ tb/tb_dsl_line_activation_fsm_unit.sv @@
// Self-checking testbench for dsl_line_activation_fsm_unit.
// Depends on dslact_pkg; a built-in activation model predicts every result item,
// driven by a directed table, random handshake sequences and random stalls.
`timescale 1ns / 100ps

module tb_dsl_line_activation_fsm_unit;
    import dslact_pkg::*;

    localparam int NTIM = 15;
    localparam int TPS  = 1000;

    localparam logic [3:0] CMD_DEACT = 4'h4;
    localparam logic [3:0] CMD_ACT   = 4'h8;
    localparam logic [3:0] CMD_SYNC  = 4'hc;

    localparam int IND_0 = 0, IND_1 = 1, IND_4 = 4, IND_7 = 7, IND_8 = 8, IND_9 = 9;
    localparam int IND_11 = 11, IND_12 = 12, IND_13 = 13, IND_15 = 15;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // req_type, ind_valid, ind_code[3:0], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // cmd_valid, cmd_code, cmd_channels, line_state,
                                      // reached_transparent, guard_expired, zero pad
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [7:0]  i_cfg_data = '0;

    dsl_line_activation_fsm_unit i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Activation tables: state, arm1, arm2, has_cmd, cmd, end timer, next.
    int lt_tab[19][7] = '{
        '{0, 255, 255, 0, 0, 255, 1}, '{1, 9, 255, 0, 0, 9, 7},
        '{18, 255, 255, 1, 0, 255, 2}, '{2, 255, 255, 0, 0, 255, 4},
        '{3, 2, 255, 0, 0, 2, 4}, '{4, 1, 2, 1, 8, 2, 5},
        '{5, 255, 255, 0, 0, 255, 6}, '{6, 1, 255, 1, 8, 255, 7},
        '{7, 5, 255, 0, 0, 5, 8}, '{8, 6, 255, 1, 10, 6, 9},
        '{9, 255, 255, 0, 0, 255, 10}, '{10, 255, 255, 1, 13, 255, 11},
        '{11, 8, 255, 0, 0, 8, 12}, '{13, 255, 255, 1, 13, 255, 10},
        '{16, 255, 255, 1, 4, 255, 0}, '{15, 255, 255, 1, 4, 255, 17},
        '{17, 255, 255, 0, 0, 255, 0}, '{14, 10, 255, 0, 0, 10, 19},
        '{19, 255, 255, 0, 0, 255, 2}};
    int nt_tab[16][7] = '{
        '{0, 7, 255, 1, 15, 7, 1}, '{18, 255, 255, 1, 15, 255, 1},
        '{1, 14, 255, 0, 0, 14, 2}, '{2, 255, 255, 1, 0, 255, 3},
        '{3, 255, 255, 0, 0, 255, 4}, '{4, 1, 11, 1, 8, 11, 5},
        '{5, 12, 255, 0, 0, 12, 8}, '{6, 255, 255, 0, 0, 255, 7},
        '{6, 255, 255, 0, 0, 1, 16}, '{7, 255, 255, 0, 0, 255, 16},
        '{8, 255, 255, 0, 0, 255, 9}, '{9, 255, 255, 1, 12, 255, 10},
        '{10, 255, 255, 0, 0, 255, 11}, '{11, 255, 255, 0, 0, 255, 15},
        '{15, 255, 255, 0, 0, 255, 16}, '{16, 13, 255, 0, 0, 13, 0}};
    int lim_ms[15] = '{0, 15000, 3, 40, 6000, 1000, 6000, 40, 24, 40, 40, 9, 5500, 15000, 0};
    int lt_ind[9] = '{1, 15, 8, 9, 7, 12, 11, 4, 13};
    int nt_ind[5] = '{8, 7, 15, 12, 0};

    bit          m_mode;
    logic [7:0]  m_chan, m_guard;
    logic [4:0]  m_state = ST_TEST;
    logic [1:0]  m_phase = PH_IDLE;
    logic [31:0] m_tick = '0, m_deadline = '0;
    logic [31:0] m_stamp[NTIM];
    logic [3:0]  line_cmds[$];
    t_result     pending_results[$];
    t_result     last_pred[$];

    int errors = 0, items_sent = 0;
    int hold_seq = 0, hold_seen = 0, rx_stall = 0;
    bit tx_quiet = 0, rx_quiet = 0;

    function automatic int row_field(int i, int f);
        return m_mode ? nt_tab[i][f] : lt_tab[i][f];
    endfunction

    function automatic int row_of(int st);
        int n;
        n = m_mode ? 16 : 19;
        for (int i = 0; i < n; i++)
            if (row_field(i, 0) == st) return i;
        return 0;
    endfunction

    function automatic void emit(logic [3:0] c);
        if (line_cmds.size() < 2) line_cmds.push_back(c);
    endfunction

    function automatic void arm_timer(int t);
        if (t < NTIM) m_stamp[t] = m_tick;
    endfunction

    function automatic void enter_state(int st);
        int i;
        i = row_of(st);
        arm_timer(row_field(i, 1));
        arm_timer(row_field(i, 2));
        if (row_field(i, 3) != 0) emit(4'(row_field(i, 4)));
    endfunction

    function automatic logic [31:0] timer_ticks(int t);
        logic [31:0] v;
        if (t == 0 || t >= NTIM) return '0;
        v = lim_ms[t] * TPS / 1000;
        return (v != 0) ? v : 32'd1;
    endfunction

    function automatic bit is_due(logic [31:0] d);
        logic [31:0] diff;
        diff = m_tick - d;
        return diff < 32'h8000_0000;
    endfunction

    function automatic int lt_indication(int s, int v);
        case (s)
            6: begin
                if (v == IND_7) return 11;
                if (v == IND_9) return 9;
                if (v == IND_15 || v == IND_11) begin emit(CMD_RESET); return 18; end
                emit(CMD_ACT); return 6;
            end
            2: begin
                if (v == IND_9) return 9;
                if (v == IND_11) begin emit(CMD_RESET); return 18; end
                emit(CMD_ACT); return 6;
            end
            7, 8: begin
                if (v == IND_7) return 11;
                if (v == IND_12) return 12;
            end
            9: begin
                if (v == IND_7) return 11;
                if (v == IND_12) return 12;
                if (v == IND_11) begin emit(CMD_RESET); return 18; end
                if (v == IND_15) begin emit(CMD_ACT); return 6; end
                return 9;
            end
            11: begin
                if (v == IND_4) begin emit(CMD_DEACT); return 5; end
                if (v == IND_12) return 12;
                if (v == IND_13) begin emit(CMD_DEACT); return 0; end
                return 11;
            end
            0: begin
                if (v == IND_8) return 6;
                if (v == IND_15) begin emit(CMD_ACT); return 2; end
            end
            17: if (v == IND_13) return 0;
            18: begin
                if (v == IND_1) begin emit(CMD_LT_UNRST); return 2; end
                if (v == IND_15) begin emit(CMD_NT_UNRST); return 2; end
            end
            5: begin
                if (v == IND_8) begin emit(CMD_ACT); return 6; end
                if (v == IND_11 || v == IND_15) begin emit(CMD_RESET); return 18; end
            end
            default: ;
        endcase
        return -1;
    endfunction

    function automatic int nt_indication(int s, int v);
        case (s)
            2: begin
                if (v == IND_8) begin emit(CMD_SYNC); return 9; end
                if (v == IND_7) begin emit(CMD_LT_UNRST); return 3; end
                return 2;
            end
            3: begin
                emit(CMD_ACT);
                return (v == IND_15) ? 4 : 3;
            end
            4: begin
                if (v == IND_8) begin emit(CMD_SYNC); return 9; end
                return 4;
            end
            5: if (v == IND_8) begin emit(CMD_SYNC); return 10; end
            9: begin
                if (v == IND_8) begin emit(CMD_SYNC); return 10; end
                if (v == IND_12) return 11;
                if (v == IND_0) begin emit(CMD_NT_UNRST); return 14; end
                return 9;
            end
            10: begin
                if (v == IND_12) return 11;
                if (v == IND_0) begin emit(CMD_NT_UNRST); return 14; end
                if (v == IND_8) emit(CMD_SYNC);
                return 10;
            end
            default: ;
        endcase
        if (v == IND_8) begin emit(CMD_SYNC); return 9; end
        return -1;
    endfunction

    function automatic int model_next(int v);
        int r, idx, n, e;
        n = m_mode ? 16 : 19;
        r = m_mode ? nt_indication(m_state, v) : lt_indication(m_state, v);
        if (r >= 0) return r;
        idx = row_of(m_state);
        for (int i = idx; i < n && row_field(i, 0) == row_field(idx, 0); i++) begin
            e = row_field(i, 5);
            if (e >= NTIM) return row_field(i, 6);
            if (m_tick - m_stamp[e] >= timer_ticks(e)) return row_field(i, 6);
        end
        return row_field(idx, 0);
    endfunction

    function automatic void predict_item(bit req, bit iv, logic [3:0] code);
        logic [31:0] gticks;
        bit done, gexp;
        int nxt, nres;
        t_result r;
        gticks = m_guard * TPS;
        done = 0;
        gexp = 0;
        line_cmds.delete();
        last_pred.delete();
        if (!req) begin
            emit(CMD_RESET);
            emit(m_mode ? CMD_NT_UNRST : CMD_LT_UNRST);
            m_state = ST_TEST;
            m_phase = PH_WAIT;
            m_deadline = m_tick + gticks;
        end else begin
            m_tick++;
            if (m_phase == PH_WAIT) begin
                if (iv || is_due(m_deadline)) begin
                    m_deadline = m_tick + gticks;
                    m_phase = PH_RUN;
                    enter_state(m_state);
                end
            end else if (m_phase == PH_RUN) begin
                nxt = model_next(iv ? int'(code) : -1);
                if (m_guard > 0 && is_due(m_deadline)) begin
                    gexp = 1;
                    m_phase = PH_IDLE;
                end else if (nxt != m_state) begin
                    m_state = 5'(nxt);
                    m_deadline = m_tick + gticks;
                    if (m_state == (m_mode ? NT_TRANSPARENT : LT_TRANSPARENT)) begin
                        done = 1;
                        m_phase = PH_IDLE;
                    end else begin
                        enter_state(nxt);
                    end
                end
            end
        end
        nres = (line_cmds.size() != 0) ? line_cmds.size() : 1;
        for (int k = 0; k < nres; k++) begin
            r.cmd_valid = k < line_cmds.size();
            r.cmd_code = r.cmd_valid ? line_cmds[k] : 4'h0;
            r.cmd_channels = r.cmd_valid ? m_chan : 8'h00;
            r.line_state = m_state;
            r.reached_transparent = done;
            r.guard_expired = gexp;
            r.last = (k == nres - 1);
            pending_results.push_back(r);
            last_pred.push_back(r);
        end
    endfunction

    // Results are sampled at the falling edge before the transfer edge.
    always @(negedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[0], m_axis_tdata[4:1], m_axis_tdata[12:5],
                   m_axis_tdata[17:13], m_axis_tdata[18], m_axis_tdata[19], m_axis_tlast};
            if (pending_results.size() == 0) begin
                errors++;
                $display("%t: unexpected result item %p", $realtime, got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%t: mismatch expected %p actual %p", $realtime, want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            rx_stall = 300;
        end
        if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!rx_quiet) begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 20) rx_stall = $urandom_range(1, 3);
                else if (r < 23) rx_stall = $urandom_range(15, 60);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (tx_quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(bit req, bit iv, logic [3:0] code);
        int g;
        g = pick_gap();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, code, iv, req};
        forever begin
            @(negedge i_clk);
            if (s_axis_tready) break;
        end
        @(posedge i_clk);
        predict_item(req, iv, code);
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TERM_MODE: m_mode = val[0];
            CFG_CHANNELS:  m_chan = val;
            CFG_GUARD:     m_guard = val;
            default: ;
        endcase
    endtask

    task automatic random_tick();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8) send_item(1'b1, 1'b0, 4'($urandom));
        else if (r < 17)
            send_item(1'b1, 1'b1, 4'(m_mode ? nt_ind[$urandom_range(0, 4)]
                                           : lt_ind[$urandom_range(0, 8)]));
        else if (r < 19) send_item(1'b1, 1'($urandom), 4'($urandom));
        else send_item(1'b0, 1'($urandom), 4'($urandom));
    endtask

    task automatic activation_run(int len);
        send_item(1'b0, 1'($urandom), 4'($urandom));
        send_item(1'b1, ($urandom_range(0, 3) != 0), 4'($urandom));
        repeat (len) random_tick();
    endtask

    typedef struct {
        bit      req;
        bit      iv;
        logic [3:0] code;
        int      n;
        t_result e0;
        t_result e1;
    } t_dir_row;

    localparam t_result NO_RES = '0;

    t_dir_row dir_rows[18] = '{
        '{1, 1, 4'hf, 1, '{0, 4'h0, 8'h00, ST_TEST, 0, 0, 1}, NO_RES},
        '{0, 0, 4'h0, 2, '{1, CMD_RESET, 8'h00, ST_TEST, 0, 0, 0},
                         '{1, CMD_LT_UNRST, 8'h00, ST_TEST, 0, 0, 1}},
        '{1, 1, 4'h0, 1, '{1, CMD_LT_UNRST, 8'h00, ST_TEST, 0, 0, 1}, NO_RES},
        '{1, 1, 4'h1, 1, '{1, CMD_LT_UNRST, 8'h00, 5'd2, 0, 0, 1}, NO_RES},
        '{1, 1, 4'h9, 1, '{0, 4'h0, 8'h00, 5'd9, 0, 0, 1}, NO_RES},
        '{1, 1, 4'hc, 1, '{0, 4'h0, 8'h00, LT_TRANSPARENT, 1, 0, 1}, NO_RES},
        '{1, 0, 4'hf, 1, '{0, 4'h0, 8'h00, LT_TRANSPARENT, 0, 0, 1}, NO_RES},
        '{0, 1, 4'hf, 0, NO_RES, NO_RES},
        '{1, 1, 4'h5, 0, NO_RES, NO_RES},
        '{1, 1, 4'hf, 0, NO_RES, NO_RES},
        '{1, 0, 4'h0, 0, NO_RES, NO_RES},
        '{1, 1, 4'h7, 0, NO_RES, NO_RES},
        '{1, 1, 4'h4, 0, NO_RES, NO_RES},
        '{1, 1, 4'h8, 0, NO_RES, NO_RES},
        '{1, 1, 4'hb, 0, NO_RES, NO_RES},
        '{0, 0, 4'ha, 0, NO_RES, NO_RES},
        '{1, 0, 4'h3, 0, NO_RES, NO_RES},
        '{1, 1, 4'hd, 0, NO_RES, NO_RES}};

    initial begin
        m_mode = 0;
        m_chan = '0;
        m_guard = '0;
        for (int t = 0; t < NTIM; t++) m_stamp[t] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].req, dir_rows[i].iv, dir_rows[i].code);
            if (dir_rows[i].n > 0 &&
                (last_pred.size() != dir_rows[i].n ||
                 last_pred[0] !== dir_rows[i].e0 ||
                 (dir_rows[i].n == 2 && last_pred[1] !== dir_rows[i].e1))) begin
                errors++;
                $display("%t: mismatch expected %p actual %p", $realtime,
                         dir_rows[i].e0, last_pred[0]);
            end
        end
        drain();

        for (int ph = 0; items_sent < 650; ph++) begin
            write_reg(CFG_TERM_MODE, 8'(ph % 2));
            write_reg(CFG_CHANNELS, (ph == 0) ? 8'h00 : (ph == 1) ? 8'hff : 8'($urandom));
            write_reg(CFG_GUARD, (ph % 3 == 2) ? 8'hff : (ph % 3 == 1) ? 8'($urandom) : 8'h00);
            tx_quiet = (ph == 3);
            rx_quiet = (ph == 4);
            if (ph == 2) begin
                hold_seq++;
                tx_quiet = 1;
                activation_run(30);
                tx_quiet = 0;
            end
            repeat (4) activation_run($urandom_range(5, 30));
            drain();
        end
        tx_quiet = 0;
        rx_quiet = 0;

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ dsl_line_activation_fsm_unit.f @@
design/dslact_pkg.sv
design/dslact_core.sv
design/dsl_line_activation_fsm_unit.sv
design/dslact_checker.sv
tb/tb_dsl_line_activation_fsm_unit.sv
